@@ rtl/pwct_pkg.sv @@
// ----------------------------------------------------------------------------
// pwct_pkg
// shared types, constants and helpers for the pulse width command transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package pwct_pkg;

   localparam int COMMAND_BITS  = 16;
   localparam int PREAMBLE_BITS = 8;
   localparam int TIMER_BITS    = 17;
   localparam int REG_BITS      = 17;
   localparam int CMD_IN_BITS   = 16;
   localparam int TOTAL_BITS    = 2 * PREAMBLE_BITS + COMMAND_BITS;
   localparam int BITS_W        = $clog2(TOTAL_BITS + 1);
   localparam int CSR_IDX_W     = 3;

   localparam logic [REG_BITS-1:0] HEADER_LOW_RST  = REG_BITS'(9000);
   localparam logic [REG_BITS-1:0] HEADER_HIGH_RST = REG_BITS'(4500);
   localparam logic [REG_BITS-1:0] ZERO_HIGH_RST   = REG_BITS'(500);
   localparam logic [REG_BITS-1:0] ONE_HIGH_RST    = REG_BITS'(1500);
   localparam logic [REG_BITS-1:0] GAP_LOW_RST     = REG_BITS'(500);
   localparam logic [REG_BITS-1:0] REST_RST        = REG_BITS'(100000);

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_LOW  = 3'd0,
      CSR_HEADER_HIGH = 3'd1,
      CSR_ZERO_HIGH   = 3'd2,
      CSR_ONE_HIGH    = 3'd3,
      CSR_GAP_LOW     = 3'd4,
      CSR_REST        = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_HDR_LOW  = 3'd1,
      PH_HDR_HIGH = 3'd2,
      PH_GAP      = 3'd3,
      PH_PULSE    = 3'd4,
      PH_TAIL     = 3'd5,
      PH_REST     = 3'd6
   } phase_type;

   typedef struct packed {
      logic [REG_BITS-1:0] header_low_ticks;
      logic [REG_BITS-1:0] header_high_ticks;
      logic [REG_BITS-1:0] zero_high_ticks;
      logic [REG_BITS-1:0] one_high_ticks;
      logic [REG_BITS-1:0] gap_low_ticks;
      logic [REG_BITS-1:0] rest_ticks;
   } cfg_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
   } result_type;

   // saturate to the timer range, zero counts as one tick
   function automatic logic [TIMER_BITS-1:0] load_len(input logic [REG_BITS-1:0] v);
      logic [TIMER_BITS-1:0] t;
      if (REG_BITS > TIMER_BITS && v > REG_BITS'(TIMER_MAX)) begin
         t = TIMER_MAX;
      end else begin
         t = TIMER_BITS'(v);
      end
      if (t == '0) begin
         t = TIMER_BITS'(1);
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pwct_csr.sv @@
// ----------------------------------------------------------------------------
// pwct_csr
// timing registers written through the csr port
// ----------------------------------------------------------------------------
`default_nettype none

module pwct_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [pwct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pwct_pkg::REG_BITS-1:0]      csr_wdata,
   output pwct_pkg::cfg_type                       cfg
);
   import pwct_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEADER_LOW:  cfg_in.header_low_ticks  = csr_wdata;
            CSR_HEADER_HIGH: cfg_in.header_high_ticks = csr_wdata;
            CSR_ZERO_HIGH:   cfg_in.zero_high_ticks   = csr_wdata;
            CSR_ONE_HIGH:    cfg_in.one_high_ticks    = csr_wdata;
            CSR_GAP_LOW:     cfg_in.gap_low_ticks     = csr_wdata;
            CSR_REST:        cfg_in.rest_ticks        = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_low_ticks  <= HEADER_LOW_RST;
         cfg_ff.header_high_ticks <= HEADER_HIGH_RST;
         cfg_ff.zero_high_ticks   <= ZERO_HIGH_RST;
         cfg_ff.one_high_ticks    <= ONE_HIGH_RST;
         cfg_ff.gap_low_ticks     <= GAP_LOW_RST;
         cfg_ff.rest_ticks        <= REST_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/pwct_core.sv @@
// ----------------------------------------------------------------------------
// pwct_core
// frame sequencer: phase, bit counter, tick timer, command shifter, line level
// ----------------------------------------------------------------------------
`default_nettype none

module pwct_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire logic                                 mode,
   input  wire logic [pwct_pkg::CMD_IN_BITS-1:0]     command,
   input  pwct_pkg::cfg_type                         cfg,
   output pwct_pkg::result_type                      result
);
   import pwct_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [BITS_W-1:0]        bits_left_ff, bits_left_in;
   logic [TIMER_BITS-1:0]    time_left_ff, time_left_in;
   logic [COMMAND_BITS-1:0]  shift_ff, shift_in;
   logic                     line_ff, line_in;
   logic                     accepted;
   logic                     busy;
   logic                     bit_val;

   assign busy = (phase_ff != PH_IDLE);

   // next data bit: preamble zeros, preamble ones, then command msb first
   always_comb begin
      if (bits_left_ff > BITS_W'(TOTAL_BITS - PREAMBLE_BITS)) begin
         bit_val = 1'b0;
      end else if (bits_left_ff > BITS_W'(TOTAL_BITS - 2 * PREAMBLE_BITS)) begin
         bit_val = 1'b1;
      end else begin
         bit_val = shift_ff[COMMAND_BITS-1];
      end
   end

   // next state
   always_comb begin
      phase_in     = phase_ff;
      bits_left_in = bits_left_ff;
      time_left_in = time_left_ff;
      shift_in     = shift_ff;
      line_in      = line_ff;
      accepted     = 1'b0;
      if (!busy) begin
         phase_in = PH_IDLE;
         line_in  = 1'b1;
      end
      if (mode) begin
         if (!busy) begin
            shift_in     = COMMAND_BITS'(command);
            bits_left_in = BITS_W'(TOTAL_BITS);
            phase_in     = PH_HDR_LOW;
            line_in      = 1'b0;
            time_left_in = load_len(cfg.header_low_ticks);
            accepted     = 1'b1;
         end
      end else if (busy) begin
         if (time_left_ff > TIMER_BITS'(1)) begin
            time_left_in = time_left_ff - TIMER_BITS'(1);
         end else begin
            case (phase_ff)
               PH_HDR_LOW: begin
                  phase_in     = PH_HDR_HIGH;
                  line_in      = 1'b1;
                  time_left_in = load_len(cfg.header_high_ticks);
               end
               PH_HDR_HIGH, PH_PULSE: begin
                  phase_in     = (bits_left_ff != '0) ? PH_GAP : PH_TAIL;
                  line_in      = 1'b0;
                  time_left_in = load_len(cfg.gap_low_ticks);
               end
               PH_GAP: begin
                  if (bits_left_ff <= BITS_W'(TOTAL_BITS - 2 * PREAMBLE_BITS)) begin
                     shift_in = {shift_ff[COMMAND_BITS-2:0], 1'b0};
                  end
                  bits_left_in = bits_left_ff - BITS_W'(1);
                  phase_in     = PH_PULSE;
                  line_in      = 1'b1;
                  time_left_in = bit_val ? load_len(cfg.one_high_ticks)
                                         : load_len(cfg.zero_high_ticks);
               end
               PH_TAIL: begin
                  line_in = 1'b1;
                  if (cfg.rest_ticks == '0) begin
                     phase_in     = PH_IDLE;
                     time_left_in = '0;
                  end else begin
                     phase_in     = PH_REST;
                     time_left_in = load_len(cfg.rest_ticks);
                  end
               end
               default: begin
                  phase_in     = PH_IDLE;
                  line_in      = 1'b1;
                  time_left_in = '0;
               end
            endcase
         end
      end
   end

   // result of this step
   always_comb begin
      result.line_level = line_in;
      result.busy_res   = (phase_in != PH_IDLE);
      result.accepted   = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bits_left_ff <= '0;
         time_left_ff <= '0;
         shift_ff     <= '0;
         line_ff      <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         bits_left_ff <= bits_left_in;
         time_left_ff <= time_left_in;
         shift_ff     <= shift_in;
         line_ff      <= line_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pwct_out.sv @@
// ----------------------------------------------------------------------------
// pwct_out
// result register with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

module pwct_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  pwct_pkg::result_type   result,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_line_level,
   output logic                   rsp_busy_res,
   output logic                   rsp_accepted
);
   import pwct_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_line_level = data_ff.line_level;
   assign rsp_busy_res   = data_ff.busy_res;
   assign rsp_accepted   = data_ff.accepted;

endmodule

`default_nettype wire

@@ rtl/pulse_width_command_transmitter_unit.sv @@
// ----------------------------------------------------------------------------
// pulse_width_command_transmitter_unit
// pulse coded command frame generator driven by start and tick words
//
// req channel: one word per step. mode 1 starts a frame with req_command,
// mode 0 is one timer tick. a start while a frame or its rest time runs is
// dropped and reported with rsp_accepted low.
// rsp channel: one word per req word, giving line level and busy after the
// step, plus the accepted flag.
// csr port: write-only timing registers, indexes 0..5, to be taken while idle:
// the user must write them only then; the block does not enforce it. the rsp
// word is registered and appears in the cycle after its req word is taken.
// throughput: one word per cycle; the sequencer updates as the word is taken
// stall: while rsp_ready is low a held rsp word blocks req_ready, so no
// word is lost; the next req is taken in the cycle the held one drains.
// reset: line high, sequencer idle, timing registers at defaults, no rsp.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_command_transmitter_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_mode,
   input  wire logic [pwct_pkg::CMD_IN_BITS-1:0]   req_command,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_line_level,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_accepted,
   input  wire logic                               csr_we,
   input  wire logic [pwct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pwct_pkg::REG_BITS-1:0]      csr_wdata
);
   import pwct_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       step;

   assign step = req_valid && req_ready;

   pwct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwct_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .mode    (req_mode),
      .command (req_command),
      .cfg     (cfg),
      .result  (result)
   );

   pwct_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (step),
      .result         (result),
      .load_ready     (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_accepted   (rsp_accepted)
   );

endmodule

`default_nettype wire

@@ dv/pulse_width_command_transmitter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// pulse_width_command_transmitter_unit_tb
// self-checking bench for the pulse width command transmitter. a queue of
// start and tick words feeds a valid/ready driver; every taken word is run
// through a cycle-free frame sequencer model in the bench and the line level,
// busy and accepted bits it predicts are checked against each rsp word.
// covers idle words at reset, the shortest and longest lengths, zero rest,
// dropped starts, random timing sets with random frames, stalls and back
// pressure.
// ----------------------------------------------------------------------------

module pulse_width_command_transmitter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pwct_pkg::*;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   localparam int RANDOM_WORDS   = 250;
   localparam int PHASE_WORDS    = 80;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2500;

   typedef struct {
      logic                   mode;
      logic [CMD_IN_BITS-1:0] command;
      int unsigned            gap;
   } cmd_word_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic                   req_mode    = 1'b0;
   logic [CMD_IN_BITS-1:0] req_command = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic                   rsp_line_level;
   logic                   rsp_busy_res;
   logic                   rsp_accepted;
   logic                   csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index   = '0;
   logic [REG_BITS-1:0]    csr_wdata   = '0;

   pulse_width_command_transmitter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_command    (req_command),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_accepted   (rsp_accepted),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   cmd_word_type pending_words[$];
   result_type   expected_line_q[$];
   cfg_type      timing_cfg = {HEADER_LOW_RST, HEADER_HIGH_RST, ZERO_HIGH_RST,
                               ONE_HIGH_RST, GAP_LOW_RST, REST_RST};

   // sequencer model
   phase_type              seq_phase     = PH_IDLE;
   logic [BITS_W-1:0]      seq_bits_left = '0;
   logic [TIMER_BITS-1:0]  seq_time_left = '0;
   logic [COMMAND_BITS-1:0] seq_shift    = '0;
   logic                   seq_line      = 1'b1;

   int           sent_total     = 0;
   int           accepted_total = 0;
   int           useful_words   = 0;
   int           ticks_to_idle  = 0;
   int           frames_started = 0;
   int           starts_dropped = 0;
   int           reg_writes     = 0;
   int           checked_words  = 0;
   int           mismatches     = 0;
   int           hold_requests  = 0;
   int           holds_served   = 0;
   int           hold_left      = 0;
   int unsigned  stall_left     = 0;
   int unsigned  send_delay     = 0;
   int           quiet_cycles   = 0;
   logic         word_held      = 1'b0;
   logic         req_gaps_on    = 1'b0;
   logic         rsp_stalls_on  = 1'b0;
   cmd_word_type next_word;
   result_type   want_word;

   function automatic logic [TIMER_BITS-1:0] ticks_of(input logic [REG_BITS-1:0] v);
      if (v == '0) return TIMER_BITS'(1);
      if (int'(v) > int'(TIMER_MAX)) return TIMER_MAX;
      return TIMER_BITS'(v);
   endfunction

   function automatic logic seq_busy();
      return (seq_phase >= PH_HDR_LOW) && (seq_phase <= PH_REST);
   endfunction

   task automatic enter_phase(input phase_type p, input logic level,
                              input logic [REG_BITS-1:0] len);
      seq_phase     = p;
      seq_line      = level;
      seq_time_left = ticks_of(len);
   endtask

   task automatic expire_phase();
      int   pos;
      logic bit_val;
      case (seq_phase)
         PH_HDR_LOW: enter_phase(PH_HDR_HIGH, 1'b1, timing_cfg.header_high_ticks);
         PH_HDR_HIGH, PH_PULSE: begin
            if (seq_bits_left != '0) enter_phase(PH_GAP, 1'b0, timing_cfg.gap_low_ticks);
            else enter_phase(PH_TAIL, 1'b0, timing_cfg.gap_low_ticks);
         end
         PH_GAP: begin
            pos = TOTAL_BITS - int'(seq_bits_left);
            if (pos < PREAMBLE_BITS) begin
               bit_val = 1'b0;
            end else if (pos < 2 * PREAMBLE_BITS) begin
               bit_val = 1'b1;
            end else begin
               bit_val   = seq_shift[COMMAND_BITS-1];
               seq_shift = seq_shift << 1;
            end
            seq_bits_left = seq_bits_left - BITS_W'(1);
            enter_phase(PH_PULSE, 1'b1, bit_val ? timing_cfg.one_high_ticks
                                                : timing_cfg.zero_high_ticks);
         end
         PH_TAIL: begin
            seq_line = 1'b1;
            if (timing_cfg.rest_ticks == '0) begin
               seq_phase     = PH_IDLE;
               seq_time_left = '0;
            end else begin
               enter_phase(PH_REST, 1'b1, timing_cfg.rest_ticks);
            end
         end
         default: begin
            seq_phase     = PH_IDLE;
            seq_line      = 1'b1;
            seq_time_left = '0;
         end
      endcase
   endtask

   task automatic predict_word(input logic mode, input logic [CMD_IN_BITS-1:0] command);
      result_type r;
      logic       was_busy;
      was_busy   = seq_busy();
      r.accepted = 1'b0;
      if (!was_busy) begin
         seq_phase = PH_IDLE;
         seq_line  = 1'b1;
      end
      if (mode == MODE_START) begin
         if (!was_busy) begin
            seq_shift     = command[COMMAND_BITS-1:0];
            seq_bits_left = BITS_W'(TOTAL_BITS);
            enter_phase(PH_HDR_LOW, 1'b0, timing_cfg.header_low_ticks);
            r.accepted = 1'b1;
            frames_started++;
         end else begin
            starts_dropped++;
         end
      end else if (was_busy) begin
         if (seq_time_left > TIMER_BITS'(1)) seq_time_left = seq_time_left - TIMER_BITS'(1);
         else expire_phase();
      end
      r.line_level = seq_line;
      r.busy_res   = seq_busy();
      expected_line_q.push_back(r);
   endtask

   // ticks from a start until the sequencer is idle again
   function automatic int frame_ticks(input logic [CMD_IN_BITS-1:0] command);
      int   n;
      logic b;
      n = int'(ticks_of(timing_cfg.header_low_ticks)) +
          int'(ticks_of(timing_cfg.header_high_ticks)) +
          int'(ticks_of(timing_cfg.gap_low_ticks));
      for (int i = 0; i < TOTAL_BITS; i++) begin
         if (i < PREAMBLE_BITS) b = 1'b0;
         else if (i < 2 * PREAMBLE_BITS) b = 1'b1;
         else b = command[COMMAND_BITS-1-(i-2*PREAMBLE_BITS)];
         n += int'(ticks_of(timing_cfg.gap_low_ticks));
         n += int'(ticks_of(b ? timing_cfg.one_high_ticks : timing_cfg.zero_high_ticks));
      end
      if (timing_cfg.rest_ticks != '0) n += int'(ticks_of(timing_cfg.rest_ticks));
      return n;
   endfunction

   function automatic logic [CMD_IN_BITS-1:0] pick_command();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return CMD_IN_BITS'(1) << $urandom_range(0, CMD_IN_BITS-1);
         default: return CMD_IN_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [REG_BITS-1:0] short_len();
      return ($urandom_range(0, 7) == 0) ? '0 : REG_BITS'($urandom_range(1, 4));
   endfunction

   function automatic cfg_type random_timing();
      cfg_type c;
      c.header_low_ticks  = short_len();
      c.header_high_ticks = short_len();
      c.zero_high_ticks   = short_len();
      c.one_high_ticks    = short_len();
      c.gap_low_ticks     = short_len();
      c.rest_ticks = ($urandom_range(0, 3) == 0) ? '0 : REG_BITS'($urandom_range(1, 12));
      return c;
   endfunction

   task automatic send_word(input logic mode, input logic [CMD_IN_BITS-1:0] command);
      cmd_word_type w;
      w.mode    = mode;
      w.command = command;
      w.gap     = req_gaps_on ? $urandom_range(0, 15) : 0;
      if (mode == MODE_START) begin
         if (ticks_to_idle == 0) begin
            ticks_to_idle = frame_ticks(command);
            useful_words++;
         end
      end else if (ticks_to_idle > 0) begin
         ticks_to_idle--;
         useful_words++;
      end
      pending_words.push_back(w);
      sent_total++;
   endtask

   task automatic finish_frame();
      while (ticks_to_idle > 0) send_word(MODE_TICK, CMD_IN_BITS'($urandom));
   endtask

   task automatic wait_drained();
      while (sent_total != accepted_total || expected_line_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_timing(input cfg_type c);
      csr_index_type idx;
      wait_drained();
      timing_cfg = c;
      idx = idx.first();
      repeat (6) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_HEADER_LOW:  csr_wdata <= c.header_low_ticks;
            CSR_HEADER_HIGH: csr_wdata <= c.header_high_ticks;
            CSR_ZERO_HIGH:   csr_wdata <= c.zero_high_ticks;
            CSR_ONE_HIGH:    csr_wdata <= c.one_high_ticks;
            CSR_GAP_LOW:     csr_wdata <= c.gap_low_ticks;
            default:         csr_wdata <= c.rest_ticks;
         endcase
         reg_writes++;
         idx = idx.next();
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(req_mode, req_command);
            accepted_total++;
         end
         if (!req_valid || req_ready) begin
            if (!word_held && pending_words.size() != 0) begin
               next_word  = pending_words.pop_front();
               word_held  = 1'b1;
               send_delay = next_word.gap;
            end
            if (word_held && send_delay == 0) begin
               req_valid   <= 1'b1;
               req_mode    <= next_word.mode;
               req_command <= next_word.command;
               word_held   = 1'b0;
            end else begin
               req_valid <= 1'b0;
               if (word_held) send_delay--;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_words++;
            if (expected_line_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp word %0d with nothing pending: line %b busy %b accepted %b",
                           checked_words, rsp_line_level, rsp_busy_res, rsp_accepted);
            end else begin
               want_word = expected_line_q.pop_front();
               if (want_word.line_level !== rsp_line_level ||
                   want_word.busy_res !== rsp_busy_res ||
                   want_word.accepted !== rsp_accepted) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp word %0d: line exp %b got %b, busy exp %b got %b, %s",
                              checked_words, want_word.line_level, rsp_line_level,
                              want_word.busy_res, rsp_busy_res,
                              $sformatf("accepted exp %b got %b",
                                        want_word.accepted, rsp_accepted));
               end
            end
            stall_left = rsp_stalls_on ? $urandom_range(0, 15) : 0;
         end
         if (holds_served < hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
            $display("pulse_width_command_transmitter_unit verification failed");
            $finish;
         end
      end
   end

   initial begin
      cfg_type plan;
      int      random_start;
      int      phase_start;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // idle words at reset timings
      send_word(MODE_TICK, '0);
      send_word(MODE_TICK, '1);
      send_word(MODE_TICK, 16'h1234);

      // all lengths zero, no rest
      plan = '0;
      load_timing(plan);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      send_word(MODE_START, 16'h0000);
      repeat (10) send_word(MODE_TICK, CMD_IN_BITS'($urandom));
      wait_drained();
      finish_frame();
      send_word(MODE_START, 16'hFFFF);
      finish_frame();
      send_word(MODE_TICK, 16'h0000);
      send_word(MODE_START, 16'h0001);
      finish_frame();

      // distinct zero and one pulses, long receiver hold
      plan.header_low_ticks  = REG_BITS'(1);
      plan.header_high_ticks = REG_BITS'(2);
      plan.zero_high_ticks   = REG_BITS'(1);
      plan.one_high_ticks    = REG_BITS'(3);
      plan.gap_low_ticks     = REG_BITS'(1);
      plan.rest_ticks        = REG_BITS'(1);
      load_timing(plan);
      hold_requests++;
      send_word(MODE_START, 16'hA5A5);
      while (ticks_to_idle > 0) begin
         send_word(MODE_TICK, CMD_IN_BITS'($urandom));
         if (ticks_to_idle > 0 && ticks_to_idle % 16 == 0)
            send_word(MODE_START, CMD_IN_BITS'($urandom));
      end

      // random timing sets with random frames
      random_start = useful_words;
      while (useful_words - random_start < RANDOM_WORDS) begin
         load_timing(random_timing());
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         phase_start   = useful_words;
         while (useful_words - phase_start < PHASE_WORDS) begin
            req_gaps_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
               0: repeat ($urandom_range(1, 6))
                     send_word(1'($urandom_range(0, 1)), CMD_IN_BITS'($urandom));
               1: begin
                  send_word(MODE_START, pick_command());
                  repeat ($urandom_range(0, 20)) send_word(MODE_TICK, CMD_IN_BITS'($urandom));
                  repeat ($urandom_range(1, 4)) send_word(MODE_START, pick_command());
               end
               default: begin
                  send_word(MODE_START, pick_command());
                  while (ticks_to_idle > 0) begin
                     if ($urandom_range(0, 19) == 0)
                        send_word(MODE_START, CMD_IN_BITS'($urandom));
                     send_word(MODE_TICK, CMD_IN_BITS'($urandom));
                  end
                  repeat ($urandom_range(0, 2)) send_word(MODE_TICK, CMD_IN_BITS'($urandom));
               end
            endcase
         end
         finish_frame();
      end

      // longest header low and rest, frame left running at the end
      plan = '0;
      plan.header_low_ticks = '1;
      plan.rest_ticks       = '1;
      load_timing(plan);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_word(MODE_START, 16'hC3A5);
      repeat (30) send_word(MODE_TICK, CMD_IN_BITS'($urandom));
      send_word(MODE_START, 16'h3C5A);
      send_word(MODE_TICK, 16'hFFFF);
      wait_drained();

      mismatches += expected_line_q.size();
      $display("covered %0d req words: %0d frames started, %0d starts dropped while busy",
               sent_total, frames_started, starts_dropped);
      $display("%0d timing register writes, %0d rsp words checked, %0d mismatches",
               reg_writes, checked_words, mismatches);
      if (mismatches == 0) begin
         $display("pulse_width_command_transmitter_unit verification clean");
      end else begin
         $display("pulse_width_command_transmitter_unit verification failed");
      end
      $finish;
   end

endmodule

@@ pulse_width_command_transmitter_unit.f @@
rtl/pwct_pkg.sv
rtl/pwct_csr.sv
rtl/pwct_core.sv
rtl/pwct_out.sv
rtl/pulse_width_command_transmitter_unit.sv
dv/pulse_width_command_transmitter_unit_tb.sv
